/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, synchronous to a clock and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: cons must hold in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dtr_pkg.sv */
// ----------------------------------------------------------------------------
// dtr_pkg
// Types, letter codes and the numeral symbol table for the Roman numeral
// converter.
// ----------------------------------------------------------------------------
package dtr_pkg;

  localparam int unsigned VALUE_W = 12;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SYM_N   = 13;
  localparam int unsigned SYM_W   = 4;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_I   = 8'h49;
  localparam logic [CHAR_W-1:0] CH_V   = 8'h56;
  localparam logic [CHAR_W-1:0] CH_X   = 8'h58;
  localparam logic [CHAR_W-1:0] CH_L   = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_C   = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D   = 8'h44;
  localparam logic [CHAR_W-1:0] CH_M   = 8'h4D;

  // One greedy symbol: its weight, first letter and optional second letter.
  typedef struct packed {
    logic [VALUE_W-1:0] weight;
    logic [CHAR_W-1:0]  first;
    logic [CHAR_W-1:0]  second;
    logic               pair;
  } sym_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
  } dtr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic step_last;
  } dtr_sts_t;

  // Symbols in descending weight; the subtractive pairs sit between.
  function automatic sym_t sym_lookup(input logic [SYM_W-1:0] idx);
    sym_t s;
    case (idx)
      4'd0:    s = '{12'd1000, CH_M, CH_NUL, 1'b0};
      4'd1:    s = '{12'd900,  CH_C, CH_M,   1'b1};
      4'd2:    s = '{12'd500,  CH_D, CH_NUL, 1'b0};
      4'd3:    s = '{12'd400,  CH_C, CH_D,   1'b1};
      4'd4:    s = '{12'd100,  CH_C, CH_NUL, 1'b0};
      4'd5:    s = '{12'd90,   CH_X, CH_C,   1'b1};
      4'd6:    s = '{12'd50,   CH_L, CH_NUL, 1'b0};
      4'd7:    s = '{12'd40,   CH_X, CH_L,   1'b1};
      4'd8:    s = '{12'd10,   CH_X, CH_NUL, 1'b0};
      4'd9:    s = '{12'd9,    CH_I, CH_X,   1'b1};
      4'd10:   s = '{12'd5,    CH_V, CH_NUL, 1'b0};
      4'd11:   s = '{12'd4,    CH_I, CH_V,   1'b1};
      default: s = '{12'd1,    CH_I, CH_NUL, 1'b0};
    endcase
    return s;
  endfunction

endpackage

/* design/dtr_datapath.sv */
// ----------------------------------------------------------------------------
// dtr_datapath
// Remainder register, pending second letter and result output register.
// Each step emits one letter by greedy symbol selection.
// ----------------------------------------------------------------------------
module dtr_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  dtr_pkg::dtr_cmd_t            cmd,
  output dtr_pkg::dtr_sts_t            sts,
  input  logic [dtr_pkg::VALUE_W-1:0]  value,
  input  logic                         result_stall,
  output logic                         result_valid,
  output logic [dtr_pkg::CHAR_W-1:0]   character,
  output logic                         empty_res,
  output logic                         last
);
  import dtr_pkg::*;

  logic [VALUE_W-1:0] residual;
  logic [VALUE_W-1:0] residual_next;
  logic               pend_vld;
  logic               pend_vld_next;
  logic [CHAR_W-1:0]  pend_char;
  logic [CHAR_W-1:0]  pend_char_next;
  logic [SYM_W-1:0]   sym_idx;
  logic               sym_found;
  sym_t               sym_cand;
  sym_t               sym;
  logic [CHAR_W-1:0]  step_char;
  logic               step_empty;
  logic               step_last;

  // Largest symbol not above the remainder: independent compares, priority pick.
  always_comb begin
    sym_idx   = SYM_W'(SYM_N - 1);
    sym_found = 1'b0;
    sym_cand  = sym_lookup(SYM_W'(0));
    for (int i = 0; i < SYM_N; i++) begin
      sym_cand = sym_lookup(SYM_W'(i));
      if (!sym_found && residual >= sym_cand.weight) begin
        sym_found = 1'b1;
        sym_idx   = SYM_W'(i);
      end
    end
  end

  assign sym = sym_lookup(sym_idx);

  always_comb begin
    residual_next  = residual;
    pend_vld_next  = pend_vld;
    pend_char_next = pend_char;
    step_char      = CH_NUL;
    step_empty     = 1'b0;
    step_last      = 1'b0;
    if (pend_vld) begin
      step_char     = pend_char;
      step_last     = (residual == '0);
      pend_vld_next = 1'b0;
    end else if (residual == '0) begin
      // zero in: a single empty result
      step_empty = 1'b1;
      step_last  = 1'b1;
    end else begin
      residual_next = residual - sym.weight;
      step_char     = sym.first;
      if (sym.pair) begin
        pend_vld_next  = 1'b1;
        pend_char_next = sym.second;
      end else begin
        step_last = (residual_next == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      residual <= value;
    end else if (cmd.step) begin
      residual  <= residual_next;
      pend_char <= pend_char_next;
    end
    if (cmd.step) begin
      character <= step_char;
      empty_res <= step_empty;
      last      <= step_last;
    end
    if (rst) begin
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend_vld <= 1'b0;
      end else if (cmd.step) begin
        pend_vld <= pend_vld_next;
      end
      if (cmd.step) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free  = !result_valid || !result_stall;
  assign sts.step_last = step_last;

endmodule

/* design/dtr_ctrl.sv */
// ----------------------------------------------------------------------------
// dtr_ctrl
// Controller: takes a value when idle, then steps the datapath once per free
// output slot until the final letter has been issued.
// ----------------------------------------------------------------------------
module dtr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  output logic               value_stall,
  output dtr_pkg::dtr_cmd_t  cmd,
  input  dtr_pkg::dtr_sts_t  sts
);
  import dtr_pkg::*;

  typedef enum logic {S_IDLE, S_CONV} state_t;

  state_t state;

  // held off in reset too, so nothing is taken that would be dropped
  assign value_stall = rst || (state != S_IDLE);
  assign cmd.load    = value_valid && !value_stall;
  assign cmd.step    = (state == S_CONV) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (cmd.step && sts.step_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/decimal_to_roman_numeral.sv */
// ----------------------------------------------------------------------------
// decimal_to_roman_numeral
// Converts a 12-bit unsigned value to its Roman numeral, one ASCII letter
// per output transaction, most significant letter first.
// ----------------------------------------------------------------------------
// A value is taken when value_valid is high and value_stall low; the block
// then issues the numeral's letters one per output transaction, with last
// set on the final letter. Zero gives one transaction with character 0 and
// both empty_res and last set. Values 4000 to 4095 carry on the same rule,
// so 4000 reads MMMM. An item is loaded first, then issues one letter per
// cycle while the output is not stalled; a numeral in the 0 to 3999 range
// has fifteen letters at most (3888 has fifteen letters).
// The letter rate is set by the single greedy step unit, which picks the
// largest symbol not above the remainder at each step; two-letter symbols
// such as CM or IV give their second letter from the pending register.
// The input is held off until the final letter has been issued, and a new
// value may be taken while that letter still waits in the output register.
// ----------------------------------------------------------------------------
module decimal_to_roman_numeral (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_stall,
  input  logic [dtr_pkg::VALUE_W-1:0]  value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [dtr_pkg::CHAR_W-1:0]   character,
  output logic                         empty_res,
  output logic                         last
);
  import dtr_pkg::*;

  // load: capture the value; step: issue the next letter into the output reg
  dtr_cmd_t cmd;
  // out_free: output register can take a letter; step_last: it will be final
  dtr_sts_t sts;

  dtr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  dtr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .character    (character),
    .empty_res    (empty_res),
    .last         (last)
  );

endmodule

/* design/dtr_checker.sv */
// ----------------------------------------------------------------------------
// dtr_checker
// Port-level checks on the Roman numeral converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtr_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  input  logic                         value_stall,
  input  logic [dtr_pkg::VALUE_W-1:0]  value,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic [dtr_pkg::CHAR_W-1:0]   character,
  input  logic                         empty_res,
  input  logic                         last
);
  import dtr_pkg::*;

  logic is_letter;
  logic in_xact;

  assign is_letter = (character == CH_I) || (character == CH_V) || (character == CH_X) ||
                     (character == CH_L) || (character == CH_C) || (character == CH_D) ||
                     (character == CH_M);
  assign in_xact   = value_valid && !value_stall && (value <= 12'hFFF);

  // the empty transaction is a lone, final NUL
  `ASSERT_SAME(a_empty_final, clk, rst, result_valid && empty_res, last && (character == CH_NUL), "empty result must be a final NUL")
  // every other transaction carries a numeral letter
  `ASSERT_SAME(a_letter, clk, rst, result_valid && !empty_res, is_letter, "result is not a numeral letter")
  // once a value is taken the input is held off while it converts
  `ASSERT_NEXT(a_busy, clk, rst, in_xact, value_stall, "input not held off after a transaction")
  // a stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(character) && $stable(last) && $stable(empty_res), "stalled result changed")

endmodule

bind decimal_to_roman_numeral dtr_checker u_dtr_checker (
  .clk          (clk),
  .rst          (rst),
  .value_valid  (value_valid),
  .value_stall  (value_stall),
  .value        (value),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .character    (character),
  .empty_res    (empty_res),
  .last         (last)
);
